// ===== hw/rtl/kss_pkg.sv =====
package kss_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int NUM_STACKS_DEF = 8;

  localparam int REQ_W    = 2;
  localparam int SID_IN_W = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/k_stacks_shared_store_top.sv =====
// Several LIFO stacks kept in one shared value store. Unused slots sit on a
// free list; each stack is a chain of slots linked from its head.
//
// Input channel (in_valid / in_stall): req_type (push, pop, peek; code 3 acts
// as a peek), stack_id and push_value. An item is taken at a clock edge with
// in_valid high and in_stall low.
// Output channel (out_valid / out_stall): status, top_value and is_empty of
// the addressed stack after the operation, one result per item.
//
// All list and head updates are done in the cycle the item is accepted, and
// the result register loads at that edge. Throughput is one item per cycle
// while the receiver keeps up; the single result register sets that figure.
// While out_stall holds a pending result, in_stall is high and the result
// does not change.
//
// Reset (rst, synchronous) empties every stack, puts all slots on the free
// list in order and clears out_valid. Slot values are not cleared; only
// slots written by a push are ever read.
module k_stacks_shared_store_top #(
  parameter int CAPACITY   = kss_pkg::CAPACITY_DEF,
  parameter int NUM_STACKS = kss_pkg::NUM_STACKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kss_pkg::REQ_W-1:0]            req_type,
  input  logic [kss_pkg::SID_IN_W-1:0]         stack_id,
  input  logic signed [kss_pkg::VAL_W-1:0]     push_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [kss_pkg::STATUS_W-1:0]         status,
  output logic signed [kss_pkg::VAL_W-1:0]     top_value,
  output logic                                 is_empty
);
  import kss_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int IDW    = (SID_W > SID_IN_W) ? SID_W : SID_IN_W;
  localparam int CW     = IDW + 1;

  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(CAPACITY);

  logic [SLOT_W-1:0]        link_store [CAPACITY];
  logic signed [VAL_W-1:0]  value_store [CAPACITY];
  logic [SLOT_W-1:0]        stack_heads [NUM_STACKS];
  logic [SLOT_W-1:0]        free_head;

  logic                     accept;
  req_t                     req;
  logic [CW-1:0]            sid_wide;
  logic [SID_W-1:0]         sid_idx;
  logic                     sid_ok;
  logic [SLOT_W-1:0]        head;
  logic                     head_ok;
  logic                     free_ok;
  logic [ADDR_W-1:0]        head_addr;
  logic [ADDR_W-1:0]        free_addr;
  logic [ADDR_W-1:0]        link_rd_addr;
  logic [SLOT_W-1:0]        link_rd;

  status_t                  status_next;
  logic [SLOT_W-1:0]        free_head_next;
  logic                     head_we;
  logic [SLOT_W-1:0]        head_wd;
  logic                     link_we;
  logic [ADDR_W-1:0]        link_wa;
  logic [SLOT_W-1:0]        link_wd;
  logic                     val_we;
  logic [SLOT_W-1:0]        rd_slot;
  logic                     rd_ok;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign req      = req_t'(req_type);

  // Stack ids past the last stack read as an always-empty stack.
  assign sid_wide = CW'(stack_id);
  assign sid_ok   = sid_wide < CW'(NUM_STACKS);
  assign sid_idx  = sid_wide[SID_W-1:0];
  assign head     = sid_ok ? stack_heads[sid_idx] : NULL_SLOT;
  assign head_ok  = head < NULL_SLOT;
  assign free_ok  = free_head < NULL_SLOT;

  assign head_addr    = head[ADDR_W-1:0];
  assign free_addr    = free_head[ADDR_W-1:0];
  assign link_rd_addr = (req == REQ_POP) ? head_addr : free_addr;
  assign link_rd      = link_store[link_rd_addr];

  assign rd_ok = rd_slot < NULL_SLOT;

  always_comb begin
    status_next    = ST_OK;
    free_head_next = free_head;
    head_we        = 1'b0;
    head_wd        = head;
    link_we        = 1'b0;
    link_wa        = free_addr;
    link_wd        = head;
    val_we         = 1'b0;
    rd_slot        = head;
    case (req)
      REQ_PUSH: begin
        if (sid_ok && free_ok) begin
          // Take the first free slot and link it in front of the stack.
          free_head_next = link_rd;
          head_we        = 1'b1;
          head_wd        = free_head;
          link_we        = 1'b1;
          link_wa        = free_addr;
          link_wd        = head;
          val_we         = 1'b1;
        end else begin
          status_next = ST_OVERFLOW;
        end
      end
      REQ_POP: begin
        if (head_ok) begin
          // Unlink the head slot and return it to the front of the free list.
          head_we        = 1'b1;
          head_wd        = link_rd;
          link_we        = 1'b1;
          link_wa        = head_addr;
          link_wd        = free_head;
          free_head_next = head;
          rd_slot        = link_rd;
        end else begin
          status_next = ST_UNDERFLOW;
        end
      end
      default: begin
        if (!head_ok) begin
          status_next = ST_UNDERFLOW;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      free_head <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_heads[i] <= NULL_SLOT;
      end
      for (int i = 0; i < CAPACITY; i++) begin
        link_store[i] <= SLOT_W'(i + 1);
      end
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        free_head <= free_head_next;
        if (head_we) begin
          stack_heads[sid_idx] <= head_wd;
        end
        if (link_we) begin
          link_store[link_wa] <= link_wd;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Value store and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (val_we) begin
        value_store[free_addr] <= push_value;
      end
      status   <= status_next;
      is_empty <= ~(val_we | rd_ok);
      if (val_we) begin
        top_value <= push_value;
      end else if (rd_ok) begin
        top_value <= value_store[rd_slot[ADDR_W-1:0]];
      end else begin
        top_value <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_push_shows_value: assert property (@(posedge clk) disable iff (rst)
    (accept && req == REQ_PUSH && sid_ok && free_ok) |=>
      (out_valid && status == ST_OK && !is_empty && top_value == $past(push_value)))
    else $error("successful push does not report the pushed value");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_UNDERFLOW) |-> (is_empty && top_value == '0))
    else $error("underflow result not reported as empty");

  a_pop_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (accept && req == REQ_POP && head_ok) |=> (free_head == $past(head)))
    else $error("popped slot not returned to the free list");

  a_free_head_code: assert property (@(posedge clk) disable iff (rst)
    free_head <= NULL_SLOT)
    else $error("free list head holds an invalid code");
`endif

endmodule

// ===== tb/sv/kss_result_checker.sv =====
`timescale 1ns / 1ps

module kss_result_checker #(
  parameter int CAPACITY   = kss_pkg::CAPACITY_DEF,
  parameter int NUM_STACKS = kss_pkg::NUM_STACKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [kss_pkg::REQ_W-1:0]        req_type,
  input  logic [kss_pkg::SID_IN_W-1:0]     stack_id,
  input  logic signed [kss_pkg::VAL_W-1:0] push_value,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [kss_pkg::STATUS_W-1:0]     status,
  input  logic signed [kss_pkg::VAL_W-1:0] top_value,
  input  logic                             is_empty,
  output int                               errors,
  output int                               pending,
  output int                               results_seen
);
  import kss_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  top;
    logic                     empty;
  } stack_result_t;

  // Shadow of the shared store; a null link is the code CAPACITY.
  logic signed [VAL_W-1:0] slot_value [CAPACITY];
  int                      slot_link  [CAPACITY];
  int                      head_of    [NUM_STACKS];
  int                      free_slot;

  stack_result_t           due_results [$];

  function automatic stack_result_t apply_request(input logic [REQ_W-1:0] rq,
                                                  input logic [SID_IN_W-1:0] sid,
                                                  input logic signed [VAL_W-1:0] v);
    int            slot;
    status_t       st;
    stack_result_t r;
    st = ST_OK;
    if (sid >= NUM_STACKS) begin
      st = (rq == REQ_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
    end else if (rq == REQ_PUSH) begin
      if (free_slot >= CAPACITY) begin
        st = ST_OVERFLOW;
      end else begin
        slot = free_slot;
        free_slot = slot_link[slot];
        slot_value[slot] = v;
        slot_link[slot] = head_of[sid];
        head_of[sid] = slot;
      end
    end else if (rq == REQ_POP) begin
      if (head_of[sid] >= CAPACITY) begin
        st = ST_UNDERFLOW;
      end else begin
        slot = head_of[sid];
        head_of[sid] = slot_link[slot];
        slot_link[slot] = free_slot;
        free_slot = slot;
      end
    end else if (head_of[sid] >= CAPACITY) begin
      // peek and the spare code 3 only report
      st = ST_UNDERFLOW;
    end
    r.status = st;
    if (sid < NUM_STACKS && head_of[sid] < CAPACITY) begin
      r.top   = slot_value[head_of[sid]];
      r.empty = 1'b0;
    end else begin
      r.top   = '0;
      r.empty = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    stack_result_t want;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_value[i] = '0;
        slot_link[i]  = i + 1;
      end
      for (int i = 0; i < NUM_STACKS; i++) head_of[i] = CAPACITY;
      free_slot = 0;
      due_results.delete();
    end else begin
      // compare first: a result leaving now belongs to an earlier item
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: status %0d top_value %0d is_empty %0d",
                   $time, status, top_value, is_empty);
        end else begin
          want = due_results.pop_front();
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
          end
          if (top_value !== want.top) begin
            errors++;
            $display("%0t: top_value expected %0d got %0d", $time, want.top, top_value);
          end
          if (is_empty !== want.empty) begin
            errors++;
            $display("%0t: is_empty expected %0d got %0d", $time, want.empty, is_empty);
          end
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(apply_request(req_type, stack_id, push_value));
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/sv/k_stacks_shared_store_top_test.sv =====
`timescale 1ns / 1ps

module k_stacks_shared_store_top_test;
  import kss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 530;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [REQ_W-1:0]        req_type   = '0;
  logic [SID_IN_W-1:0]     stack_id   = '0;
  logic signed [VAL_W-1:0] push_value = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] top_value;
  logic                    is_empty;

  int errors;
  int pending;
  int results_seen;
  int cycles     = 0;
  int stall_left = 0;
  bit idle_on    = 1'b1;
  int n_push     = 0;
  int n_pop      = 0;
  int n_query    = 0;

  k_stacks_shared_store_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .stack_id   (stack_id),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .top_value  (top_value),
    .is_empty   (is_empty)
  );

  kss_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .stack_id     (stack_id),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .top_value    (top_value),
    .is_empty     (is_empty),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (idle_on && stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("k_stacks_shared_store_top test failed");
      $finish;
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] rq,
                              input logic [SID_IN_W-1:0] sid,
                              input logic signed [VAL_W-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    stack_id   <= sid;
    push_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (rq)
      REQ_PUSH: n_push++;
      REQ_POP:  n_pop++;
      default:  n_query++;
    endcase
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                      push_pct;
    int                      pick;
    logic [REQ_W-1:0]        rq;
    logic [SID_IN_W-1:0]     sid;
    logic signed [VAL_W-1:0] v;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty stack handling, extreme values, every request code
    send_request(REQ_PEEK, 3'd0, 32'sd0);
    send_request(REQ_POP,  3'd0, 32'sd0);
    send_request(REQ_PUSH, 3'd0, 32'sh7FFFFFFF);
    send_request(REQ_PUSH, 3'd0, 32'sh80000000);
    send_request(REQ_PEEK, 3'd0, 32'sd0);
    send_request(2'd3,     3'd0, 32'shFFFFFFFF);
    send_request(REQ_POP,  3'd0, 32'sd0);
    send_request(REQ_PUSH, 3'd7, -32'sd1);
    send_request(REQ_PUSH, 3'd7, 32'sd0);
    send_request(REQ_PEEK, 3'd7, 32'sd0);
    send_request(2'd3,     3'd3, 32'sd0);
    send_request(REQ_POP,  3'd7, 32'sd0);
    send_request(REQ_POP,  3'd7, 32'sd0);
    send_request(REQ_POP,  3'd7, 32'sd0);
    send_request(REQ_PEEK, 3'd7, 32'sd0);
    send_request(REQ_PUSH, 3'd3, 32'sh55555555);
    send_request(REQ_PUSH, 3'd3, 32'shAAAAAAAA);
    send_request(REQ_POP,  3'd3, 32'sd0);
    send_request(REQ_PUSH, 3'd5, 32'sd1);
    send_request(REQ_PEEK, 3'd5, 32'sd0);
    send_request(REQ_POP,  3'd0, 32'sd0);
    send_request(REQ_POP,  3'd0, 32'sd0);
    drain_results();

    // segments alternate between filling, churning and draining the store
    push_pct = 90;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0 && i != 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 90;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      if (i == 270) drain_results();
      if (i == RANDOM_ITEMS - 80) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
        rq = REQ_PUSH;
      else if (pick < push_pct + (100 - push_pct) * 3 / 4)
        rq = REQ_POP;
      else
        rq = REQ_W'($urandom_range(2, 3));
      // crowd some items onto two stacks so chains get deep
      sid = SID_IN_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       v = 32'sh7FFFFFFF;
        1:       v = 32'sh80000000;
        default: v = $urandom;
      endcase
      send_request(rq, sid, v);
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Ran %0d pushes, %0d pops and %0d peek queries over 8 stacks sharing one store,",
             n_push, n_pop, n_query);
    $display("including store overflow and empty-stack cases; %0d results checked.",
             results_seen);
    if (errors == 0)
      $display("k_stacks_shared_store_top test passed");
    else
      $display("k_stacks_shared_store_top test failed");
    $finish;
  end

endmodule
